// ===== rtl/core/sfe_pkg.sv =====
// Shared types and constants of the serial frame encoder.
package sfe_pkg;

  // Largest number of stream bytes that one request can produce
  localparam int unsigned BURST_MAX = 7;
  localparam int unsigned BURST_CNT_W = 3;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

  // Register reset values
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] STOP_MARKER_RST  = 8'h55;
  localparam logic [8:0] LENGTH_LIMIT_RST = 9'd256;

  // Configuration register set
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
    logic [8:0] length_limit;
  } cfg_t;

  // One byte of the framed stream with its flags
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       rejected;
  } entry_t;

  // All stream bytes caused by one request; ent[0] goes out first
  typedef struct packed {
    logic [BURST_CNT_W-1:0]     count;
    entry_t [BURST_MAX-1:0]     ent;
  } burst_t;

endpackage

// ===== rtl/core/sfe_if.sv =====
// Channel interfaces of the serial frame encoder: input, result and configuration.
interface sfe_in_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic [7:0]  msg_id;
  logic [15:0] payload_len;
  logic [7:0]  data_byte;

  modport source (output valid, output first, output msg_id, output payload_len,
                  output data_byte, input ready);
  modport sink (input valid, input first, input msg_id, input payload_len,
                input data_byte, output ready);
endinterface

interface sfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_last;
  logic       frame_end;
  logic       rejected;

  modport source (output valid, output tx_byte, output run_last, output frame_end,
                  output rejected, input ready);
  modport sink (input valid, input tx_byte, input run_last, input frame_end,
                input rejected, output ready);
endinterface

interface sfe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfe_pkg::CFG_IDX_W-1:0]  index;
  logic [sfe_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/sfe_cfg_regs.sv =====
// Configuration register file of the serial frame encoder.
module sfe_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  sfe_cfg_if.sink        cfg_chan,
  output sfe_pkg::cfg_t  cfg
);

  sfe_pkg::cfg_t cfg_r;
  sfe_pkg::cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_chan.ready = 1'b1;

  // Decode a write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        sfe_pkg::REG_START_MARKER: cfg_nxt.start_marker = cfg_chan.wdata[7:0];
        sfe_pkg::REG_STOP_MARKER:  cfg_nxt.stop_marker  = cfg_chan.wdata[7:0];
        sfe_pkg::REG_LENGTH_LIMIT: cfg_nxt.length_limit = cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= sfe_pkg::START_MARKER_RST;
      cfg_r.stop_marker  <= sfe_pkg::STOP_MARKER_RST;
      cfg_r.length_limit <= sfe_pkg::LENGTH_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/sfe_frame_logic.sv =====
// Frame state and per-request byte burst builder of the serial frame encoder.
module sfe_frame_logic #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            first,
  input  logic [7:0]      msg_id,
  input  logic [15:0]     payload_len,
  input  logic [7:0]      data_byte,
  input  sfe_pkg::cfg_t   cfg,
  output sfe_pkg::burst_t burst
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic        open_r,  open_nxt;
  logic [15:0] exp_r,   exp_nxt;
  logic [15:0] sent_r,  sent_nxt;
  logic [7:0]  sum_r,   sum_nxt;

  logic [15:0] limit_cfg;
  logic [15:0] limit_eff;
  logic        too_long;
  logic [7:0]  len_lo;
  logic [7:0]  len_hi;
  logic [7:0]  hdr_sum;
  logic [7:0]  hdr_data_sum;
  logic [7:0]  run_sum;
  logic [15:0] sent_inc;

  // Limit in force is the smaller of the register and the build maximum
  assign limit_cfg = {7'd0, cfg.length_limit};
  assign limit_eff = (MaxLen < limit_cfg) ? MaxLen : limit_cfg;
  assign too_long  = payload_len > limit_eff;

  assign len_lo       = payload_len[7:0];
  assign len_hi       = payload_len[15:8];
  assign hdr_sum      = msg_id + len_lo + len_hi;
  assign hdr_data_sum = hdr_sum + data_byte;
  assign run_sum      = sum_r + data_byte;
  assign sent_inc     = sent_r + 16'd1;

  // Build the burst and the next frame state
  always_comb begin
    burst    = '0;
    open_nxt = open_r;
    exp_nxt  = exp_r;
    sent_nxt = sent_r;
    sum_nxt  = sum_r;
    if (first) begin
      open_nxt = 1'b0;
      if (too_long) begin
        burst.ent[0] = '{tx_byte: 8'd0, frame_end: 1'b0, rejected: 1'b1};
        burst.count  = 3'd1;
      end else begin
        open_nxt = 1'b1;
        exp_nxt  = payload_len;
        sent_nxt = 16'd0;
        sum_nxt  = hdr_sum;
        burst.ent[0] = '{tx_byte: cfg.start_marker, frame_end: 1'b0, rejected: 1'b0};
        burst.ent[1] = '{tx_byte: msg_id, frame_end: 1'b0, rejected: 1'b0};
        burst.ent[2] = '{tx_byte: len_lo, frame_end: 1'b0, rejected: 1'b0};
        burst.ent[3] = '{tx_byte: len_hi, frame_end: 1'b0, rejected: 1'b0};
        if (payload_len == 16'd0) begin
          // empty payload: trailer right after the header
          burst.ent[4] = '{tx_byte: ~hdr_sum, frame_end: 1'b0, rejected: 1'b0};
          burst.ent[5] = '{tx_byte: cfg.stop_marker, frame_end: 1'b1, rejected: 1'b0};
          burst.count  = 3'd6;
          open_nxt     = 1'b0;
        end else begin
          burst.ent[4] = '{tx_byte: data_byte, frame_end: 1'b0, rejected: 1'b0};
          sum_nxt      = hdr_data_sum;
          sent_nxt     = 16'd1;
          if (payload_len == 16'd1) begin
            burst.ent[5] = '{tx_byte: ~hdr_data_sum, frame_end: 1'b0, rejected: 1'b0};
            burst.ent[6] = '{tx_byte: cfg.stop_marker, frame_end: 1'b1, rejected: 1'b0};
            burst.count  = 3'd7;
            open_nxt     = 1'b0;
          end else begin
            burst.count  = 3'd5;
          end
        end
      end
    end else if (open_r) begin
      // payload byte of an open frame
      burst.ent[0] = '{tx_byte: data_byte, frame_end: 1'b0, rejected: 1'b0};
      sum_nxt      = run_sum;
      sent_nxt     = sent_inc;
      if (sent_inc >= exp_r) begin
        burst.ent[1] = '{tx_byte: ~run_sum, frame_end: 1'b0, rejected: 1'b0};
        burst.ent[2] = '{tx_byte: cfg.stop_marker, frame_end: 1'b1, rejected: 1'b0};
        burst.count  = 3'd3;
        open_nxt     = 1'b0;
      end else begin
        burst.count  = 3'd1;
      end
    end
  end

  // Frame state advances on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      exp_r  <= 16'd0;
      sent_r <= 16'd0;
      sum_r  <= 8'd0;
    end else if (accept) begin
      open_r <= open_nxt;
      exp_r  <= exp_nxt;
      sent_r <= sent_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ===== rtl/core/sfe_burst_out.sv =====
// Result register of the serial frame encoder: holds one burst and shifts it out.
module sfe_burst_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sfe_pkg::burst_t burst,
  output logic            load_ok,
  sfe_out_if.source       out_chan
);

  logic [sfe_pkg::BURST_CNT_W-1:0]          cnt_r, cnt_nxt;
  sfe_pkg::entry_t [sfe_pkg::BURST_MAX-1:0] ent_r, ent_nxt;
  sfe_pkg::entry_t [sfe_pkg::BURST_MAX-1:0] ent_shift;
  logic                                     take;

  assign take = out_chan.valid && out_chan.ready;

  // A new burst may load once the held one is empty or its last byte leaves
  assign load_ok = (cnt_r == '0) || ((cnt_r == 3'd1) && out_chan.ready);

  // Move every byte one place toward the output
  always_comb begin
    for (int i = 0; i < sfe_pkg::BURST_MAX - 1; i++) begin
      ent_shift[i] = ent_r[i+1];
    end
    ent_shift[sfe_pkg::BURST_MAX-1] = '0;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (load) begin
      cnt_nxt = burst.count;
      ent_nxt = burst.ent;
    end else if (take) begin
      cnt_nxt = cnt_r - 3'd1;
      ent_nxt = ent_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // Output side
  assign out_chan.valid     = cnt_r != '0;
  assign out_chan.tx_byte   = ent_r[0].tx_byte;
  assign out_chan.frame_end = ent_r[0].frame_end;
  assign out_chan.rejected  = ent_r[0].rejected;
  assign out_chan.run_last  = cnt_r == 3'd1;

`ifndef NO_ASSERTIONS
  // loading while bytes remain only happens as the last one leaves
  a_load_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_chan.valid) |-> (cnt_r == 3'd1 && out_chan.ready))
    else $error("burst loaded over pending bytes");

  // burst length never exceeds the worst case
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(sfe_pkg::BURST_MAX))
    else $error("burst count out of range");

  // a stop byte always closes the request's burst
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.frame_end) |-> (out_chan.run_last && !out_chan.rejected))
    else $error("stop byte not last of burst");

  // a reject is a lone zero byte
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.rejected) |->
      (out_chan.run_last && out_chan.tx_byte == 8'd0))
    else $error("malformed reject result");

  // after the last byte is taken with nothing loaded, the output goes idle
  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_chan.run_last && !load) |=> !out_chan.valid)
    else $error("output valid after drain");
`endif

endmodule

// ===== rtl/core/serial_frame_encoder_core.sv =====
// Top level of the serial frame encoder: framing with start/stop markers and checksum.
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        first, msg_id, payload_len, data_byte
//  out_chan  out  valid/ready        tx_byte, run_last, frame_end, rejected
//  cfg_chan  in   valid/ready(=1)    index, wdata
//
// A request is taken once the held burst is empty or its last byte is leaving, and
// is turned into 0 to 7 stream bytes in one pass. Output runs at one byte per cycle
// while out_chan is ready, so payload bytes then stream at 1 per cycle and a frame
// header or trailer adds 4 or 2 bytes on the single output port.
// Reset (rst_n low, synchronous) clears the frame state, the burst count and the
// registers to their defaults. A stall on out_chan holds the burst and in_chan.
module serial_frame_encoder_core #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  sfe_in_if.sink    in_chan,
  sfe_out_if.source out_chan,
  sfe_cfg_if.sink   cfg_chan
);

  sfe_pkg::cfg_t   cfg;
  sfe_pkg::burst_t burst;
  logic            load_ok;
  logic            accept;

  assign in_chan.ready = load_ok;
  assign accept        = in_chan.valid && load_ok;

  // Registers
  sfe_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Frame state and burst build
  sfe_frame_logic #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .first       (in_chan.first),
    .msg_id      (in_chan.msg_id),
    .payload_len (in_chan.payload_len),
    .data_byte   (in_chan.data_byte),
    .cfg         (cfg),
    .burst       (burst)
  );

  // Result register and serializer
  sfe_burst_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .burst    (burst),
    .load_ok  (load_ok),
    .out_chan (out_chan)
  );

endmodule
